FILE: src/fsbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsbl_pkg
// Shared types and constants of the per-source flood blocker.
// ----------------------------------------------------------------------------
package fsbl_pkg;

	// Opcodes of an input transaction
	localparam logic OP_MESSAGE = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	// Configuration register indexes
	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] CFG_BLOCK   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_UNBLOCK = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_TIMEOUT = 2'd2;

	// Reset values of the configuration registers
	localparam logic [15:0] RST_BLOCK   = 16'd20;
	localparam logic [15:0] RST_UNBLOCK = 16'd5;
	localparam logic [15:0] RST_TIMEOUT = 16'd60;

	// Milliseconds per second, and ceil(2^41 / 1000) for exact x / 1000
	localparam logic [31:0] MS_PER_S    = 32'd1000;
	localparam logic [31:0] RECIP_1000  = 32'd2199023256;
	localparam int          RECIP_SHIFT = 41;

	typedef struct packed {
		logic        opcode;
		logic [31:0] source_id;
		logic [31:0] time_ms;
	} req_t;

	typedef struct packed {
		logic       blocked;
		logic       dropped_no_room;
		logic       sweep_ran;
		logic [6:0] entries_in_use;
	} rsp_t;

	// One table entry as held in the memory
	typedef struct packed {
		logic        valid;
		logic [31:0] source;
		logic [31:0] first_ms;
		logic [31:0] last_ms;
		logic [31:0] count;
		logic        blocked;
	} rec_t;

	// Controller to datapath
	typedef struct packed {
		logic load_item;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic track_free;
		logic clr_wr;
		logic msg_hit_wr;
		logic msg_new_wr;
		logic exp_wr;
		logic mul_en;
		logic div_start;
		logic blk_wr;
		logic sweep_start;
		logic set_blk;
		logic set_drop;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_update;
		logic due;
		logic idx_last;
		logic rec_valid;
		logic hit;
		logic expired;
		logic free_vld;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

FILE: src/fsbl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsbl_div
// Restoring unsigned 32 / 32 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsbl_div import fsbl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;

	// Shift in the next dividend bit and try to subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[31]};
		diff   = rem_sh - {1'b0, dvs_q};
	end

	// Track the step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Advance remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: src/fsbl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsbl_dp
// Datapath: entry memory, scan index, sweep arithmetic, config and result.
// ----------------------------------------------------------------------------
module fsbl_dp import fsbl_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire req_t              req,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output rsp_t                   rsp
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	logic [15:0]   blk_th_q;
	logic [15:0]   unblk_th_q;
	logic [15:0]   tmo_q;
	req_t          item_q;
	logic [31:0]   last_sweep_q;
	logic [IW-1:0] idx_q;
	logic          free_vld_q;
	logic [IW-1:0] free_idx_q;
	logic [CW-1:0] in_use_q;
	rec_t          rd_q;
	logic [63:0]   prod_s1;
	logic          res_blk_q;
	logic          res_drop_q;
	logic          res_ran_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	rec_t          mem [TABLE_ENTRIES];

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	rec_t          wr_data;
	logic [31:0]   idle_ms;
	logic [31:0]   limit_ms;
	logic [22:0]   act_raw;
	logic [31:0]   active;
	logic [31:0]   rate;
	logic          div_done;
	logic          new_blk;
	logic [31:0]   use_wide;

	// Configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_th_q   <= RST_BLOCK;
			unblk_th_q <= RST_UNBLOCK;
			tmo_q      <= RST_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK:   blk_th_q   <= cfg_data;
				CFG_UNBLOCK: unblk_th_q <= cfg_data;
				CFG_TIMEOUT: tmo_q      <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Sweep arithmetic
	always_comb begin
		idle_ms  = item_q.time_ms - rd_q.last_ms;
		limit_ms = {16'd0, tmo_q} * MS_PER_S;
		act_raw  = prod_s1[63:RECIP_SHIFT];
		active   = (act_raw == '0) ? 32'd1 : {9'd0, act_raw};
		if (rate > {16'd0, blk_th_q}) begin
			new_blk = 1'b1;
		end else if (rate < {16'd0, unblk_th_q}) begin
			new_blk = 1'b0;
		end else begin
			new_blk = rd_q.blocked;
		end
	end

	fsbl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_q.count),
		.divisor  (active),
		.done     (div_done),
		.quotient (rate)
	);

	// Select the memory write
	always_comb begin
		wr_en   = cmd.clr_wr | cmd.msg_hit_wr | cmd.msg_new_wr | cmd.exp_wr | cmd.blk_wr;
		wr_addr = idx_q;
		wr_data = rd_q;
		priority if (cmd.clr_wr) begin
			wr_data = '0;
		end else if (cmd.msg_hit_wr) begin
			if (rd_q.count != 32'hFFFF_FFFF) begin
				wr_data.count = rd_q.count + 32'd1;
			end
			wr_data.last_ms = item_q.time_ms;
		end else if (cmd.msg_new_wr) begin
			wr_addr          = free_idx_q;
			wr_data.valid    = 1'b1;
			wr_data.source   = item_q.source_id;
			wr_data.first_ms = item_q.time_ms;
			wr_data.last_ms  = item_q.time_ms;
			wr_data.count    = 32'd1;
			wr_data.blocked  = 1'b0;
		end else if (cmd.exp_wr) begin
			wr_data.valid = 1'b0;
		end else if (cmd.blk_wr) begin
			wr_data.blocked = new_blk;
		end else begin
			wr_data = rd_q;
		end
	end

	// Entry memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[idx_q];
		end
	end

	// Capture the item and the rate product
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req;
		end
		if (cmd.mul_en) begin
			prod_s1 <= {32'd0, item_q.time_ms - rd_q.first_ms} * {32'd0, RECIP_1000};
		end
	end

	// Scan index, free slot, occupancy and sweep time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			free_vld_q   <= 1'b0;
			free_idx_q   <= '0;
			in_use_q     <= '0;
			last_sweep_q <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.load_item) begin
				free_vld_q <= 1'b0;
			end else if (cmd.track_free && !rd_q.valid && !free_vld_q) begin
				free_vld_q <= 1'b1;
				free_idx_q <= idx_q;
			end
			if (cmd.msg_new_wr) begin
				in_use_q <= in_use_q + CW'(1);
			end else if (cmd.exp_wr) begin
				in_use_q <= in_use_q - CW'(1);
			end
			if (cmd.sweep_start) begin
				last_sweep_q <= item_q.time_ms;
			end
		end
	end

	// Result flags and output register
	assign use_wide = 32'(in_use_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_blk_q   <= 1'b0;
			res_drop_q  <= 1'b0;
			res_ran_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				res_blk_q  <= 1'b0;
				res_drop_q <= 1'b0;
				res_ran_q  <= 1'b0;
			end else begin
				if (cmd.set_blk) begin
					res_blk_q <= rd_q.blocked;
				end
				if (cmd.set_drop) begin
					res_drop_q <= 1'b1;
				end
				if (cmd.sweep_start) begin
					res_ran_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.blocked         <= res_blk_q;
			rsp_q.dropped_no_room <= res_drop_q;
			rsp_q.sweep_ran       <= res_ran_q;
			rsp_q.entries_in_use  <= use_wide[6:0];
		end
	end

	// Status toward the controller
	always_comb begin
		sts.is_update = (item_q.opcode == OP_UPDATE);
		sts.due       = (item_q.time_ms - last_sweep_q) >= MS_PER_S;
		sts.idx_last  = (idx_q == LAST_IDX);
		sts.rec_valid = rd_q.valid;
		sts.hit       = rd_q.valid && (rd_q.source == item_q.source_id);
		sts.expired   = idle_ms > limit_ms;
		sts.free_vld  = free_vld_q;
		sts.div_done  = div_done;
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

FILE: src/fsbl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsbl_ctrl
// Controller: clearing pass, message scan, sweep sequencing, result handoff.
// ----------------------------------------------------------------------------
module fsbl_ctrl import fsbl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_MSG_RD,
		ST_MSG_CMP,
		ST_MSG_NEW,
		ST_SW_RD,
		ST_SW_EVAL,
		ST_SW_MUL,
		ST_SW_DIV,
		ST_OUT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign req_stall = (state_q != ST_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = ST_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					cmd.idx_clr   = 1'b1;
					state_nxt     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (!sts.is_update) begin
					state_nxt = ST_MSG_RD;
				end else if (sts.due) begin
					cmd.sweep_start = 1'b1;
					state_nxt       = ST_SW_RD;
				end else begin
					state_nxt = ST_OUT;
				end
			end
			ST_MSG_RD: begin
				cmd.rd_en = 1'b1;
				state_nxt = ST_MSG_CMP;
			end
			ST_MSG_CMP: begin
				cmd.track_free = 1'b1;
				if (sts.hit) begin
					cmd.msg_hit_wr = 1'b1;
					cmd.set_blk    = 1'b1;
					state_nxt      = ST_OUT;
				end else if (sts.idx_last) begin
					state_nxt = ST_MSG_NEW;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = ST_MSG_RD;
				end
			end
			ST_MSG_NEW: begin
				if (sts.free_vld) begin
					cmd.msg_new_wr = 1'b1;
				end else begin
					cmd.set_drop = 1'b1;
				end
				state_nxt = ST_OUT;
			end
			ST_SW_RD: begin
				cmd.rd_en = 1'b1;
				state_nxt = ST_SW_EVAL;
			end
			ST_SW_EVAL: begin
				if (sts.rec_valid && !sts.expired) begin
					cmd.mul_en = 1'b1;
					state_nxt  = ST_SW_MUL;
				end else begin
					cmd.exp_wr = sts.rec_valid;
					if (sts.idx_last) begin
						state_nxt = ST_OUT;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nxt   = ST_SW_RD;
					end
				end
			end
			ST_SW_MUL: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_SW_DIV;
			end
			ST_SW_DIV: begin
				if (sts.div_done) begin
					cmd.blk_wr = 1'b1;
					if (sts.idx_last) begin
						state_nxt = ST_OUT;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nxt   = ST_SW_RD;
					end
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: src/per_source_flood_blocker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_flood_blocker_unit
// Per-source message rate limiter with block/unblock hysteresis.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+----------------------------------------
//   req     | req_valid/req_stall  | opcode, source_id, time_ms
//   rsp     | rsp_valid/rsp_stall  | blocked, dropped_no_room, sweep_ran,
//           |                      | entries_in_use
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// A message scans the entries up to a hit through the single registered read
// port, with a read state and a compare state per entry. A sweep reads every
// entry, and each live entry that has not expired passes through the
// bit-serial rate divider; an early update goes straight to the result.
// After reset a clearing pass over all TABLE_ENTRIES entries stalls the input.
// One transaction is in work at a time; a stalled result holds the finish.
// ----------------------------------------------------------------------------
module per_source_flood_blocker_unit import fsbl_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output rsp_t                   rsp,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [15:0]       cfg_data
);

	cmd_t cmd;
	sts_t sts;

	fsbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fsbl_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

FILE: src/fsbl_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsbl_chk
// Port-level checks of the flood blocker, bound to the top level.
// ----------------------------------------------------------------------------
module fsbl_chk import fsbl_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	localparam logic [31:0] FULL = 32'(TABLE_ENTRIES);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// A sweep result carries no message flags, and a drop is never blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.sweep_ran && (rsp.blocked || rsp.dropped_no_room))
			&& !(rsp.blocked && rsp.dropped_no_room))
		else $error("conflicting result flags");

	// A drop only happens with a full table
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.dropped_no_room |-> rsp.entries_in_use == FULL[6:0])
		else $error("drop with free entries");

	// One transaction at a time: input stalls right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second transaction taken while busy");

endmodule

bind per_source_flood_blocker_unit fsbl_chk #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_chk (.*);
`default_nettype wire
